FILE: sv/tpf_pkg.sv
package tpf_pkg;

  // physical buffer geometry
  localparam int FB_WIDTH    = 128;
  localparam int FB_HEIGHT   = 64;
  localparam int FB_PAGES    = (FB_HEIGHT + 7) / 8;
  localparam int STORE_BYTES = FB_WIDTH * FB_PAGES;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  // width of the unclipped byte address sum
  localparam int AF_W        = ADDR_W + 9;

  // command codes
  localparam logic [2:0] CMD_CLEAR = 3'd0;
  localparam logic [2:0] CMD_PIXEL = 3'd1;
  localparam logic [2:0] CMD_HRUN  = 3'd2;
  localparam logic [2:0] CMD_VRUN  = 3'd3;
  localparam logic [2:0] CMD_RECT  = 3'd4;
  localparam logic [2:0] CMD_GLYPH = 3'd5;
  localparam logic [2:0] CMD_READ  = 3'd6;
  localparam logic [2:0] CMD_CLEAN = 3'd7;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_VIS_W = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VIS_H = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_OFF = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_OFF = 2'd3;

  // configuration reset values
  localparam logic [7:0] VIS_W_RST = 8'd72;
  localparam logic [6:0] VIS_H_RST = 7'd40;
  localparam logic [6:0] X_OFF_RST = 7'd28;
  localparam logic [5:0] Y_OFF_RST = 6'd24;

  typedef struct packed {
    logic [7:0] vis_w;
    logic [6:0] vis_h;
    logic [6:0] x_off;
    logic [5:0] y_off;
  } cfg_t;

  // result of mapping one logical point onto the store
  typedef struct packed {
    logic              in_win;
    logic              in_buf;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        mask;
  } plot_t;

  // single port store request
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
  } mem_req_t;

  // five columns, bit r of a column is row r
  typedef logic [0:4][7:0] shape_t;

  localparam shape_t FONT [36] = '{
    '{8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E}, '{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00},
    '{8'h42, 8'h61, 8'h51, 8'h49, 8'h46}, '{8'h21, 8'h41, 8'h45, 8'h4B, 8'h31},
    '{8'h18, 8'h14, 8'h12, 8'h7F, 8'h10}, '{8'h27, 8'h45, 8'h45, 8'h45, 8'h39},
    '{8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30}, '{8'h01, 8'h71, 8'h09, 8'h05, 8'h03},
    '{8'h36, 8'h49, 8'h49, 8'h49, 8'h36}, '{8'h06, 8'h49, 8'h49, 8'h29, 8'h1E},
    '{8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E}, '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h36},
    '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h22}, '{8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C},
    '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h41}, '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h01},
    '{8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A}, '{8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F},
    '{8'h00, 8'h41, 8'h7F, 8'h41, 8'h00}, '{8'h20, 8'h40, 8'h41, 8'h3F, 8'h01},
    '{8'h7F, 8'h08, 8'h14, 8'h22, 8'h41}, '{8'h7F, 8'h40, 8'h40, 8'h40, 8'h40},
    '{8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F}, '{8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F},
    '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E}, '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h06},
    '{8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E}, '{8'h7F, 8'h09, 8'h19, 8'h29, 8'h46},
    '{8'h46, 8'h49, 8'h49, 8'h49, 8'h31}, '{8'h01, 8'h01, 8'h7F, 8'h01, 8'h01},
    '{8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F}, '{8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F},
    '{8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F}, '{8'h63, 8'h14, 8'h08, 8'h14, 8'h63},
    '{8'h07, 8'h08, 8'h70, 8'h08, 8'h07}, '{8'h61, 8'h51, 8'h49, 8'h45, 8'h43}
  };

  localparam shape_t SHAPE_FALLBACK = '{8'h7E, 8'h09, 8'h09, 8'h00, 8'h06};
  localparam shape_t SHAPE_BLANK    = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
  localparam shape_t SHAPE_DOTS     = '{8'h00, 8'h36, 8'h36, 8'h00, 8'h00};
  localparam shape_t SHAPE_DASH     = '{8'h08, 8'h08, 8'h08, 8'h08, 8'h08};
  localparam shape_t SHAPE_SLASH    = '{8'h40, 8'h30, 8'h08, 8'h06, 8'h01};

  // character code to glyph, lower case folded onto upper case
  function automatic shape_t glyph_shape(input logic [7:0] code);
    logic [7:0] c;
    shape_t     s;
    c = code;
    if (c >= 8'h61 && c <= 8'h7A) begin
      c = c - 8'h20;
    end
    if (code == 8'h20) begin
      s = SHAPE_BLANK;
    end else if (code >= 8'h30 && code <= 8'h39) begin
      s = FONT[6'(code - 8'h30)];
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      s = FONT[6'(c - 8'h41) + 6'd10];
    end else if (c == 8'h3A || c == 8'h2E) begin
      s = SHAPE_DOTS;
    end else if (c == 8'h2D || c == 8'h5F) begin
      s = SHAPE_DASH;
    end else if (c == 8'h2F) begin
      s = SHAPE_SLASH;
    end else begin
      s = SHAPE_FALLBACK;
    end
    return s;
  endfunction

endpackage

FILE: sv/tpf_store.sv
module tpf_store (
  input  logic                clk,
  input  tpf_pkg::mem_req_t   req,
  output logic [7:0]          rdata
);

  logic [7:0] mem_r [tpf_pkg::STORE_BYTES];
  logic [7:0] rdata_r;

  // one port: a write (when req.we) and a read of one address, read data registered
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.addr] <= req.wdata;
    end
    rdata_r <= mem_r[req.addr];
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/tpf_plot.sv
module tpf_plot (
  input  logic signed [10:0] px,
  input  logic signed [10:0] py,
  input  tpf_pkg::cfg_t      cfg,
  output tpf_pkg::plot_t     plot
);

  logic                         win;
  logic [8:0]                   phys_x;
  logic [7:0]                   phys_y;
  logic [tpf_pkg::AF_W-1:0]     row_base;
  logic [tpf_pkg::AF_W-1:0]     addr_full;
  logic                         buf_ok;

  // clip to the logical window
  assign win = !px[10] && !py[10] &&
               (px < $signed({3'b000, cfg.vis_w})) &&
               (py < $signed({4'b0000, cfg.vis_h}));

  // shift to physical coordinates, values are small once inside the window
  assign phys_x = {1'b0, px[7:0]} + {2'b00, cfg.x_off};
  assign phys_y = {1'b0, py[6:0]} + {2'b00, cfg.y_off};

  // page layout byte address
  assign row_base  = tpf_pkg::AF_W'(phys_y[7:3]) * tpf_pkg::AF_W'(tpf_pkg::FB_WIDTH);
  assign addr_full = row_base + tpf_pkg::AF_W'(phys_x);

  // clip to the physical buffer
  assign buf_ok = (32'(phys_x) < 32'(tpf_pkg::FB_WIDTH)) &&
                  (32'(phys_y) < 32'(tpf_pkg::FB_HEIGHT)) &&
                  (32'(addr_full) < 32'(tpf_pkg::STORE_BYTES));

  always_comb begin
    plot.in_win = win;
    plot.in_buf = buf_ok;
    plot.addr   = addr_full[tpf_pkg::ADDR_W-1:0];
    plot.mask   = 8'h01 << phys_y[2:0];
  end

endmodule

FILE: sv/text_pixel_framebuffer_top.sv
// Monochrome framebuffer with line, rectangle and 5x7 text drawing.
// Input channel (in_*): one command per transfer, accepted when in_valid is
// high and in_stall is low. Every command returns exactly one result transfer
// on the out_* channel: the byte read (zero unless a read command) and the
// dirty flag after the command. Results come out in command order.
// Each pixel is visited by one shared point unit: only an S_PT visit if it falls
// outside the window or outside the buffer (or is a blank glyph bit), else a
// read-modify-write through the single store port, S_PT then S_WR.
// One command is in work at a time; the next one is taken once the result
// of the previous one has been handed to the output register.
// After reset the store is wiped by a sweep over all STORE_BYTES addresses
// with in_stall high; configuration writes on cfg_* are taken at any time.
// While out_stall holds a result, the output register keeps it steady and a
// finished later command waits until the register is free.
module text_pixel_framebuffer_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_we,
  input  logic [tpf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_wdata,
  // commands
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    in_command,
  input  logic signed [8:0]             in_x_pos,
  input  logic signed [8:0]             in_y_pos,
  input  logic [7:0]                    in_run_width,
  input  logic [7:0]                    in_run_height,
  input  logic [7:0]                    in_char_code,
  input  logic                          in_pixel_on,
  input  logic [9:0]                    in_read_index,
  // results
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    out_read_byte,
  output logic                          out_dirty
);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_PT   = 3'd2;
  localparam logic [2:0] S_WR   = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_RDC  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]                  state_r, state_nxt;
  logic                        clr_cmd_r;
  logic [tpf_pkg::ADDR_W-1:0]  clr_cnt_r;
  logic                        clr_last;
  logic                        changed_r;
  tpf_pkg::cfg_t               cfg_r;

  // command context
  logic [2:0]                  cmd_r;
  logic signed [8:0]           x_r, y_r;
  logic [7:0]                  w_r, h_r;
  logic                        on_r;
  logic [9:0]                  ridx_r;
  tpf_pkg::shape_t             shape_r;
  logic                        glyph_r;

  // point walker
  logic [1:0]                  seg_r;
  logic                        horiz_r;
  logic [7:0]                  len_r, idx_r;
  logic [7:0]                  dx_r, dy_r;

  // read-modify-write hold
  logic [tpf_pkg::ADDR_W-1:0]  addr_r;
  logic [7:0]                  mask_r;
  logic [7:0]                  rb_r;

  // output register
  logic                        out_valid_r;
  logic [7:0]                  out_rb_r;
  logic                        out_dirty_r;

  logic                        accept;
  logic                        slot_free;
  logic signed [10:0]          pt_x, pt_y;
  tpf_pkg::plot_t              plot;
  logic                        pt_en;
  logic                        go_rmw;
  tpf_pkg::mem_req_t           mem_req;
  logic [7:0]                  mem_rdata;

  // next point of the walk
  logic                        adv_done;
  logic                        adv_load_seg;
  logic [1:0]                  adv_seg;
  logic [7:0]                  adv_dx, adv_dy, adv_idx, adv_len;
  logic                        adv_horiz;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign slot_free = !out_valid_r || !out_stall;
  assign clr_last  = (clr_cnt_r == tpf_pkg::ADDR_W'(tpf_pkg::STORE_BYTES - 1));

  // shared point unit: origin plus walk offset
  assign pt_x = $signed({{2{x_r[8]}}, x_r}) + $signed({3'b000, dx_r});
  assign pt_y = $signed({{2{y_r[8]}}, y_r}) + $signed({3'b000, dy_r});

  tpf_plot u_plot (
    .px   (pt_x),
    .py   (pt_y),
    .cfg  (cfg_r),
    .plot (plot)
  );

  assign pt_en  = glyph_r ? shape_r[dx_r[2:0]][dy_r[2:0]] : 1'b1;
  assign go_rmw = pt_en && plot.in_win && plot.in_buf;

  // walk step: glyph rows then columns, runs along their segment
  always_comb begin
    adv_done     = 1'b0;
    adv_load_seg = 1'b0;
    adv_seg      = seg_r;
    adv_dx       = dx_r;
    adv_dy       = dy_r;
    adv_idx      = idx_r + 8'd1;
    adv_len      = len_r;
    adv_horiz    = horiz_r;
    if (glyph_r) begin
      if (dy_r == 8'd6) begin
        adv_dy = 8'd0;
        if (dx_r == 8'd4) begin
          adv_done = 1'b1;
        end else begin
          adv_dx = dx_r + 8'd1;
        end
      end else begin
        adv_dy = dy_r + 8'd1;
      end
    end else if (idx_r == len_r - 8'd1) begin
      if (cmd_r == tpf_pkg::CMD_RECT && seg_r != 2'd3) begin
        adv_load_seg = 1'b1;
        adv_seg      = seg_r + 2'd1;
        adv_idx      = 8'd0;
        unique case (seg_r + 2'd1)
          2'd1: begin
            adv_dx = 8'd0; adv_dy = h_r - 8'd1; adv_horiz = 1'b1; adv_len = w_r;
          end
          2'd2: begin
            adv_dx = 8'd0; adv_dy = 8'd0; adv_horiz = 1'b0; adv_len = h_r;
          end
          2'd3: begin
            adv_dx = w_r - 8'd1; adv_dy = 8'd0; adv_horiz = 1'b0; adv_len = h_r;
          end
          default: begin
            adv_dx = 8'd0; adv_dy = 8'd0; adv_horiz = 1'b1; adv_len = w_r;
          end
        endcase
      end else begin
        adv_done = 1'b1;
      end
    end else if (horiz_r) begin
      adv_dx = dx_r + 8'd1;
    end else begin
      adv_dy = dy_r + 8'd1;
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR: begin
        if (clr_last) begin
          state_nxt = clr_cmd_r ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          unique case (in_command)
            tpf_pkg::CMD_CLEAR: state_nxt = S_CLR;
            tpf_pkg::CMD_PIXEL: state_nxt = S_PT;
            tpf_pkg::CMD_HRUN:  state_nxt = (in_run_width == 8'd0) ? S_DONE : S_PT;
            tpf_pkg::CMD_VRUN:  state_nxt = (in_run_height == 8'd0) ? S_DONE : S_PT;
            tpf_pkg::CMD_RECT: begin
              state_nxt = (in_run_width == 8'd0 || in_run_height == 8'd0) ? S_DONE : S_PT;
            end
            tpf_pkg::CMD_GLYPH: state_nxt = S_PT;
            tpf_pkg::CMD_READ:  state_nxt = S_RD;
            tpf_pkg::CMD_CLEAN: state_nxt = S_DONE;
            default:            state_nxt = S_DONE;
          endcase
        end
      end
      S_PT: begin
        if (go_rmw) begin
          state_nxt = S_WR;
        end else if (adv_done) begin
          state_nxt = S_DONE;
        end
      end
      S_WR:   state_nxt = adv_done ? S_DONE : S_PT;
      S_RD:   state_nxt = S_RDC;
      S_RDC:  state_nxt = S_DONE;
      S_DONE: state_nxt = slot_free ? S_IDLE : S_DONE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // store port steering
  always_comb begin
    mem_req.we    = 1'b0;
    mem_req.addr  = addr_r;
    mem_req.wdata = 8'h00;
    unique case (state_r)
      S_CLR: begin
        mem_req.we   = 1'b1;
        mem_req.addr = clr_cnt_r;
      end
      S_PT: mem_req.addr = plot.addr;
      S_WR: begin
        mem_req.we    = 1'b1;
        mem_req.wdata = on_r ? (mem_rdata | mask_r) : (mem_rdata & ~mask_r);
      end
      S_RD: mem_req.addr = tpf_pkg::ADDR_W'(ridx_r);
      default: mem_req.addr = addr_r;
    endcase
  end

  tpf_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cmd_r   <= 1'b0;
      clr_cnt_r   <= '0;
      changed_r   <= 1'b0;
      out_valid_r <= 1'b0;
      cfg_r.vis_w <= tpf_pkg::VIS_W_RST;
      cfg_r.vis_h <= tpf_pkg::VIS_H_RST;
      cfg_r.x_off <= tpf_pkg::X_OFF_RST;
      cfg_r.y_off <= tpf_pkg::Y_OFF_RST;
    end else begin
      state_r <= state_nxt;

      // register writes
      if (cfg_we) begin
        unique case (cfg_index)
          tpf_pkg::REG_VIS_W: cfg_r.vis_w <= cfg_wdata;
          tpf_pkg::REG_VIS_H: cfg_r.vis_h <= cfg_wdata[6:0];
          tpf_pkg::REG_X_OFF: cfg_r.x_off <= cfg_wdata[6:0];
          tpf_pkg::REG_Y_OFF: cfg_r.y_off <= cfg_wdata[5:0];
          default: ;
        endcase
      end

      // clear sweep counter
      if (state_r == S_CLR) begin
        clr_cnt_r <= clr_last ? '0 : clr_cnt_r + tpf_pkg::ADDR_W'(1);
      end

      // dirty tracking
      if (accept && in_command == tpf_pkg::CMD_CLEAR) begin
        changed_r <= 1'b1;
      end else if (accept && in_command == tpf_pkg::CMD_CLEAN) begin
        changed_r <= 1'b0;
      end else if (state_r == S_PT && pt_en && plot.in_win) begin
        changed_r <= 1'b1;
      end

      if (accept) begin
        clr_cmd_r <= (in_command == tpf_pkg::CMD_CLEAR);
      end

      // output handshake
      if (state_r == S_DONE && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // command context and walker
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_command;
      x_r     <= in_x_pos;
      y_r     <= in_y_pos;
      w_r     <= in_run_width;
      h_r     <= in_run_height;
      ridx_r  <= in_read_index;
      shape_r <= tpf_pkg::glyph_shape(in_char_code);
      glyph_r <= (in_command == tpf_pkg::CMD_GLYPH);
      on_r    <= (in_command == tpf_pkg::CMD_GLYPH) ? 1'b1 : in_pixel_on;
      rb_r    <= 8'h00;
      seg_r   <= 2'd0;
      idx_r   <= 8'd0;
      dx_r    <= 8'd0;
      dy_r    <= 8'd0;
      horiz_r <= (in_command != tpf_pkg::CMD_VRUN);
      unique case (in_command)
        tpf_pkg::CMD_PIXEL: len_r <= 8'd1;
        tpf_pkg::CMD_VRUN:  len_r <= in_run_height;
        default:            len_r <= in_run_width;
      endcase
    end else if ((state_r == S_PT && !go_rmw) || state_r == S_WR) begin
      dx_r  <= adv_dx;
      dy_r  <= adv_dy;
      idx_r <= adv_idx;
      if (adv_load_seg) begin
        seg_r   <= adv_seg;
        len_r   <= adv_len;
        horiz_r <= adv_horiz;
      end
    end

    // hold the byte address across the read-modify-write
    if (state_r == S_PT && go_rmw) begin
      addr_r <= plot.addr;
      mask_r <= plot.mask;
    end

    // read command data, zero beyond the store
    if (state_r == S_RDC) begin
      rb_r <= (32'(ridx_r) < 32'(tpf_pkg::STORE_BYTES)) ? mem_rdata : 8'h00;
    end

    // result payload
    if (state_r == S_DONE && slot_free) begin
      out_rb_r    <= rb_r;
      out_dirty_r <= changed_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_byte = out_rb_r;
  assign out_dirty     = out_dirty_r;

endmodule
